/* hdl/btki_pkg.sv */
package btki_pkg;

    localparam int OUT_W    = 10;
    localparam int PLAYER_W = 4;

    localparam logic CMD_CLEAR  = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

endpackage

/* hdl/binary_trie_key_insert.sv */
// Channel  | Signals                                  | Beat taken when
// ---------+------------------------------------------+-------------------------
// Command  | start, busy, cmd, player, key            | start high and busy low
// Result   | done, leaf, nodes_used, leaf_new, status | done high (one cycle)
//
// A clear sets its result registers straight from the command and never leaves idle.
// An insert walks the trie one level per step, reading each child's links from the
// child memory (the root's links sit in a register), then checks for room, links one
// new node per missing level plus the leaf and registers its result; a known key links none.
// Reset empties the trie at once; the child memory needs no clearing pass.
// Results cannot be stalled; the next command is taken in the cycle its result shows.
module binary_trie_key_insert #(
    parameter int NODE_COUNT = 1024,
    parameter int KEY_BITS   = 11,
    parameter int PLAYERS    = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           cmd,
    input  logic [btki_pkg::PLAYER_W-1:0]  player,
    input  logic [KEY_BITS-1:0]            key,
    output logic                           done,
    output logic [btki_pkg::OUT_W-1:0]     leaf,
    output logic [btki_pkg::OUT_W-1:0]     nodes_used,
    output logic                           leaf_new,
    output logic                           status
);

    import btki_pkg::*;

    localparam int NW = $clog2(NODE_COUNT);
    localparam int LW = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int PW = $clog2(PLAYERS);
    localparam int SW = NW + 6;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_LINK  = 3'd3;
    localparam logic [2:0] S_LAST  = 3'd4;

    typedef logic [1:0][NW-1:0] links_t;

    links_t mem [NODE_COUNT];
    links_t rd_q;
    logic [NW-1:0] player_mem [PLAYERS];

    logic [2:0]          state_reg, state_next;
    links_t              root_reg, root_next;
    links_t              cur_reg, cur_next;
    logic [NW-1:0]       node_reg, node_next;
    logic [NW-1:0]       total_reg, total_next;
    logic [LW-1:0]       lvl_reg, lvl_next;
    logic                miss_reg, miss_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [PLAYER_W-1:0] player_reg, player_next;
    logic                done_reg, done_next;
    logic [OUT_W-1:0]    leaf_reg, leaf_next;
    logic [OUT_W-1:0]    used_reg, used_next;
    logic                new_reg, new_next;
    logic                status_reg, status_next;

    logic                rd_en;
    logic [NW-1:0]       rd_addr;
    logic                wr_en;
    logic [NW-1:0]       wr_addr;
    links_t              wr_data;
    logic                plr_we;
    logic [NW-1:0]       plr_data;

    links_t              links_now;
    links_t              links_upd;
    logic [NW-1:0]       child;
    logic [NW-1:0]       total_inc;
    logic [SW-1:0]       need_sum;
    logic                key_bit;
    logic                player_ok;

    always_comb
    begin
        key_bit   = key_reg[lvl_reg];
        links_now = (node_reg == '0) ? root_reg : rd_q;
        child     = links_now[key_bit];
        total_inc = total_reg + NW'(1);
        need_sum  = SW'(total_reg) + SW'(lvl_reg) + SW'(1);
        links_upd = cur_reg;
        links_upd[key_bit] = total_inc;
        player_ok = (32'(player_reg) < PLAYERS);

        state_next  = state_reg;
        root_next   = root_reg;
        cur_next    = cur_reg;
        node_next   = node_reg;
        total_next  = total_reg;
        lvl_next    = lvl_reg;
        miss_next   = miss_reg;
        key_next    = key_reg;
        player_next = player_reg;
        done_next   = 1'b0;
        leaf_next   = leaf_reg;
        used_next   = used_reg;
        new_next    = new_reg;
        status_next = status_reg;
        rd_en       = 1'b0;
        rd_addr     = child;
        wr_en       = 1'b0;
        wr_addr     = node_reg;
        wr_data     = links_upd;
        plr_we      = 1'b0;
        plr_data    = node_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd == CMD_CLEAR)
                    begin
                        total_next  = '0;
                        root_next   = '0;
                        done_next   = 1'b1;
                        leaf_next   = '0;
                        used_next   = '0;
                        new_next    = 1'b0;
                        status_next = STATUS_DONE;
                    end
                    else
                    begin
                        key_next    = key;
                        player_next = player;
                        node_next   = '0;
                        lvl_next    = LW'(KEY_BITS - 1);
                        state_next  = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                if (child == '0)
                begin
                    cur_next   = links_now;
                    miss_next  = 1'b1;
                    state_next = S_CHECK;
                end
                else if (lvl_reg == '0)
                begin
                    node_next  = child;
                    miss_next  = 1'b0;
                    state_next = S_CHECK;
                end
                else
                begin
                    node_next = child;
                    lvl_next  = lvl_reg - LW'(1);
                    rd_en     = 1'b1;
                end
            end
            S_CHECK:
            begin
                if (miss_reg && (need_sum > SW'(NODE_COUNT - 1)))
                begin
                    done_next   = 1'b1;
                    leaf_next   = '0;
                    used_next   = OUT_W'(total_reg);
                    new_next    = 1'b0;
                    status_next = STATUS_FULL;
                    state_next  = S_IDLE;
                end
                else if (miss_reg)
                begin
                    state_next = S_LINK;
                end
                else
                begin
                    plr_we      = player_ok;
                    done_next   = 1'b1;
                    leaf_next   = OUT_W'(node_reg);
                    used_next   = OUT_W'(total_reg);
                    new_next    = 1'b0;
                    status_next = STATUS_DONE;
                    state_next  = S_IDLE;
                end
            end
            S_LINK:
            begin
                if (node_reg == '0)
                begin
                    root_next = links_upd;
                end
                else
                begin
                    wr_en = 1'b1;
                end
                node_next  = total_inc;
                total_next = total_inc;
                cur_next   = '0;
                if (lvl_reg == '0)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    lvl_next = lvl_reg - LW'(1);
                end
            end
            S_LAST:
            begin
                wr_en       = 1'b1;
                wr_data     = '0;
                plr_we      = player_ok;
                done_next   = 1'b1;
                leaf_next   = OUT_W'(node_reg);
                used_next   = OUT_W'(total_reg);
                new_next    = 1'b1;
                status_next = STATUS_DONE;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            root_reg  <= '0;
            total_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            root_reg  <= root_next;
            total_reg <= total_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        node_reg   <= node_next;
        lvl_reg    <= lvl_next;
        miss_reg   <= miss_next;
        key_reg    <= key_next;
        player_reg <= player_next;
        leaf_reg   <= leaf_next;
        used_reg   <= used_next;
        new_reg    <= new_next;
        status_reg <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (plr_we)
        begin
            player_mem[PW'(player_reg)] <= plr_data;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign leaf       = leaf_reg;
    assign nodes_used = used_reg;
    assign leaf_new   = new_reg;
    assign status     = status_reg;

endmodule
